/* design/i2cm_pkg.sv */
// shared types, codes and phase tables for the i2c master bit engine
package i2cm_pkg;

   // command codes carried in the mode field
   typedef enum logic [2:0] {
      MODE_NONE     = 3'd0,
      MODE_START    = 3'd1,
      MODE_STOP     = 3'd2,
      MODE_SEND     = 3'd3,
      MODE_READ     = 3'd4,
      MODE_ACK      = 3'd5,
      MODE_NACK     = 3'd6,
      MODE_WAIT_ACK = 3'd7
   } mode_type;

   // line action of one phase: drive low, release, keep, or send data bit
   typedef enum logic [1:0] {
      LVL_LOW  = 2'd0,
      LVL_HIGH = 2'd1,
      LVL_KEEP = 2'd2,
      LVL_DATA = 2'd3
   } lvl_type;

   typedef struct packed {
      lvl_type scl;
      lvl_type sda;
   } phase_type;

   localparam logic [15:0] PHASE_TICKS_RESET = 16'd10;
   localparam logic [3:0]  LAST_BIT          = 4'd7;

   // one input word as held in the input register
   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] tx_byte;
      logic       sda_in;
   } req_item_type;

   // one result word
   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_status;
   } rsp_item_type;

   // number of phases in one command (per bit for send and read)
   function automatic logic [2:0] phase_count(input mode_type cmd);
      logic [2:0] n;
      case (cmd)
         MODE_START:    n = 3'd2;
         MODE_STOP:     n = 3'd2;
         MODE_SEND:     n = 3'd4;
         MODE_READ:     n = 3'd3;
         MODE_ACK:      n = 3'd5;
         MODE_NACK:     n = 3'd3;
         MODE_WAIT_ACK: n = 3'd4;
         default:       n = 3'd0;
      endcase
      return n;
   endfunction

   // scl and sda action of each phase
   function automatic phase_type phase_entry(input mode_type cmd, input logic [2:0] phase);
      phase_type e;
      e = '{scl: LVL_LOW, sda: LVL_LOW};
      case (cmd)
         MODE_START: begin
            case (phase)
               3'd0:    e = '{scl: LVL_HIGH, sda: LVL_HIGH};
               3'd1:    e = '{scl: LVL_KEEP, sda: LVL_LOW};
               default: e = '{scl: LVL_LOW,  sda: LVL_LOW};
            endcase
         end
         MODE_STOP: begin
            case (phase)
               3'd0:    e = '{scl: LVL_HIGH, sda: LVL_LOW};
               3'd1:    e = '{scl: LVL_KEEP, sda: LVL_HIGH};
               default: e = '{scl: LVL_LOW,  sda: LVL_LOW};
            endcase
         end
         MODE_SEND: begin
            case (phase)
               3'd0:    e = '{scl: LVL_LOW,  sda: LVL_LOW};
               3'd1:    e = '{scl: LVL_KEEP, sda: LVL_DATA};
               3'd2:    e = '{scl: LVL_HIGH, sda: LVL_KEEP};
               3'd3:    e = '{scl: LVL_LOW,  sda: LVL_KEEP};
               default: e = '{scl: LVL_LOW,  sda: LVL_LOW};
            endcase
         end
         MODE_READ: begin
            case (phase)
               3'd0:    e = '{scl: LVL_LOW,  sda: LVL_KEEP};
               3'd1:    e = '{scl: LVL_HIGH, sda: LVL_KEEP};
               3'd2:    e = '{scl: LVL_LOW,  sda: LVL_KEEP};
               default: e = '{scl: LVL_LOW,  sda: LVL_LOW};
            endcase
         end
         MODE_ACK: begin
            case (phase)
               3'd0:    e = '{scl: LVL_LOW,  sda: LVL_HIGH};
               3'd1:    e = '{scl: LVL_KEEP, sda: LVL_LOW};
               3'd2:    e = '{scl: LVL_HIGH, sda: LVL_KEEP};
               3'd3:    e = '{scl: LVL_LOW,  sda: LVL_KEEP};
               3'd4:    e = '{scl: LVL_KEEP, sda: LVL_HIGH};
               default: e = '{scl: LVL_LOW,  sda: LVL_LOW};
            endcase
         end
         MODE_NACK: begin
            case (phase)
               3'd0:    e = '{scl: LVL_LOW,  sda: LVL_HIGH};
               3'd1:    e = '{scl: LVL_HIGH, sda: LVL_KEEP};
               3'd2:    e = '{scl: LVL_LOW,  sda: LVL_KEEP};
               default: e = '{scl: LVL_LOW,  sda: LVL_LOW};
            endcase
         end
         MODE_WAIT_ACK: begin
            case (phase)
               3'd0:    e = '{scl: LVL_LOW,  sda: LVL_HIGH};
               3'd1:    e = '{scl: LVL_HIGH, sda: LVL_KEEP};
               3'd2:    e = '{scl: LVL_KEEP, sda: LVL_KEEP};
               3'd3:    e = '{scl: LVL_LOW,  sda: LVL_KEEP};
               default: e = '{scl: LVL_LOW,  sda: LVL_LOW};
            endcase
         end
         default: e = '{scl: LVL_LOW, sda: LVL_LOW};
      endcase
      return e;
   endfunction

endpackage

/* design/i2cm_channels.sv */
// valid/ready channel interfaces for request and response words

interface i2cm_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] mode;
   logic [7:0] tx_byte;
   logic       sda_in;

   modport source (output valid, output mode, output tx_byte, output sda_in, input ready);
   modport sink   (input valid, input mode, input tx_byte, input sda_in, output ready);
endinterface

interface i2cm_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_out;
   logic       sda_out;
   logic       busy_res;
   logic       done_res;
   logic [7:0] rx_byte;
   logic       ack_status;

   modport source (output valid, output scl_out, output sda_out, output busy_res,
                   output done_res, output rx_byte, output ack_status, input ready);
   modport sink   (input valid, input scl_out, input sda_out, input busy_res,
                   input done_res, input rx_byte, input ack_status, output ready);
endinterface

/* design/i2cm_in_stage.sv */
// input register stage for request words
module i2cm_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   i2cm_req_if.sink              req_ch,
   input  logic                  take,
   output logic                  item_valid,
   output i2cm_pkg::req_item_type item
);
   import i2cm_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         accept;

   // room when empty or when the held word moves on this cycle
   assign req_ch.ready = !valid_ff || take;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload capture
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= '{mode: req_ch.mode, tx_byte: req_ch.tx_byte, sda_in: req_ch.sda_in};
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;
endmodule

/* design/i2cm_engine.sv */
// bit engine state and next-state logic, advanced one tick per word
module i2cm_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [15:0]            csr_wr_data,
   input  logic                   step,
   input  i2cm_pkg::req_item_type item,
   output i2cm_pkg::rsp_item_type result
);
   import i2cm_pkg::*;

   logic [15:0] phase_ticks_ff;
   mode_type    cmd_ff,   cmd_in;
   logic [2:0]  phase_ff, phase_in;
   logic [15:0] tick_ff,  tick_in;
   logic [3:0]  bit_ff,   bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  read_ff,  read_in;
   logic        ack_ff,   ack_in;
   logic [1:0]  lines_ff, lines_in;

   logic [15:0] limit;
   logic [15:0] tick_inc;
   logic        done;
   logic        apply;
   phase_type   ph;
   mode_type    mode;

   assign limit = (phase_ticks_ff == 16'd0) ? 16'd1 : phase_ticks_ff;
   assign mode  = mode_type'(item.mode);

   // phase timing, sampling and command sequencing
   always_comb begin
      cmd_in   = cmd_ff;
      phase_in = phase_ff;
      tick_in  = tick_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      read_in  = read_ff;
      ack_in   = ack_ff;
      done     = 1'b0;
      apply    = 1'b0;
      tick_inc = (tick_ff != 16'hFFFF) ? tick_ff + 16'd1 : tick_ff;
      if (cmd_ff != MODE_NONE) begin
         tick_in = tick_inc;
         if (tick_inc >= limit) begin
            tick_in = 16'd0;
            // sample sda as the scl-high phase ends
            if (phase_ff == 3'd1 && cmd_ff == MODE_READ) begin
               shift_in = {shift_ff[6:0], item.sda_in};
            end
            if (phase_ff == 3'd1 && cmd_ff == MODE_WAIT_ACK) begin
               ack_in = item.sda_in;
            end
            if ({1'b0, phase_ff} + 4'd1 >= {1'b0, phase_count(cmd_ff)}) begin
               if (cmd_ff == MODE_SEND) begin
                  shift_in = {shift_in[6:0], 1'b0};
               end
               if ((cmd_ff == MODE_SEND || cmd_ff == MODE_READ) && bit_ff < LAST_BIT) begin
                  bit_in   = bit_ff + 4'd1;
                  phase_in = 3'd0;
                  apply    = 1'b1;
               end else begin
                  if (cmd_ff == MODE_READ) begin
                     read_in = shift_in;
                  end
                  cmd_in   = MODE_NONE;
                  phase_in = 3'd0;
                  done     = 1'b1;
               end
            end else begin
               phase_in = phase_ff + 3'd1;
               apply    = 1'b1;
            end
         end
      end else if (mode != MODE_NONE) begin
         cmd_in   = mode;
         phase_in = 3'd0;
         tick_in  = 16'd0;
         bit_in   = 4'd0;
         shift_in = (mode == MODE_SEND) ? item.tx_byte : 8'd0;
         apply    = 1'b1;
      end
   end

   // line levels of the phase just entered
   assign ph = phase_entry(cmd_in, phase_in);

   always_comb begin
      lines_in = lines_ff;
      if (apply) begin
         if (ph.scl != LVL_KEEP) begin
            lines_in[1] = ph.scl[0];
         end
         if (ph.sda == LVL_DATA) begin
            lines_in[0] = shift_in[7];
         end else if (ph.sda != LVL_KEEP) begin
            lines_in[0] = ph.sda[0];
         end
      end
   end

   // result word for this tick
   always_comb begin
      result.scl_out    = lines_in[1];
      result.sda_out    = lines_in[0];
      result.busy_res   = (cmd_in != MODE_NONE);
      result.done_res   = done;
      result.rx_byte    = read_in;
      result.ack_status = ack_in;
   end

   // state commit
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff   <= MODE_NONE;
         phase_ff <= 3'd0;
         tick_ff  <= 16'd0;
         bit_ff   <= 4'd0;
         shift_ff <= 8'd0;
         read_ff  <= 8'd0;
         ack_ff   <= 1'b0;
         lines_ff <= 2'b11;
      end else if (step) begin
         cmd_ff   <= cmd_in;
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         read_ff  <= read_in;
         ack_ff   <= ack_in;
         lines_ff <= lines_in;
      end
   end

   // phase length register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= PHASE_TICKS_RESET;
      end else if (csr_wr_en) begin
         phase_ticks_ff <= csr_wr_data;
      end
   end
endmodule

/* design/i2cm_out_stage.sv */
// output register stage for response words
module i2cm_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  i2cm_pkg::rsp_item_type item,
   output logic                   free,
   i2cm_rsp_if.source             rsp_ch
);
   import i2cm_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   // slot frees when empty or when the held word is taken
   assign free = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item;
      end
   end

   assign rsp_ch.valid      = valid_ff;
   assign rsp_ch.scl_out    = item_ff.scl_out;
   assign rsp_ch.sda_out    = item_ff.sda_out;
   assign rsp_ch.busy_res   = item_ff.busy_res;
   assign rsp_ch.done_res   = item_ff.done_res;
   assign rsp_ch.rx_byte    = item_ff.rx_byte;
   assign rsp_ch.ack_status = item_ff.ack_status;
endmodule

/* design/i2c_master_bit_engine_top.sv */
// i2c master bit engine: input register, tick engine, output register
//
// Each request word is one tick of the bit timer. It carries a command code
// (start, stop, send byte, read byte, ack, nack, wait ack), the byte to send
// and the sampled sda level. An idle engine starts the command it receives;
// a command seen while busy is dropped. Every tick yields exactly one
// response word with the scl/sda drive, busy, a done pulse, the last read
// byte and the last ack status.
// csr_wr_en/csr_wr_data set the phase length in ticks (reset 10, 0 acts
// as 1); write it only while the engine is idle.
// A taken request word waits in the input register; its response word
// is held in the output register. Throughput: one word per cycle while
// rsp_ch takes words, set by the single engine state update per tick.
// Reset clears both stages and returns the engine to idle with both lines
// released. When the response side stalls, the output register holds its
// word, the input register holds the next one, and req_ch.ready drops.
module i2c_master_bit_engine_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   i2cm_req_if.sink    req_ch,
   i2cm_rsp_if.source  rsp_ch
);
   import i2cm_pkg::*;

   logic         in_valid;
   logic         out_free;
   logic         step;
   req_item_type in_item;
   rsp_item_type out_item;

   // one tick is processed when a word is held and the output slot is free
   assign step = in_valid && out_free;

   i2cm_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .take       (step),
      .item_valid (in_valid),
      .item       (in_item)
   );

   i2cm_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step        (step),
      .item        (in_item),
      .result      (out_item)
   );

   i2cm_out_stage u_out_stage (
      .clock  (clock),
      .reset  (reset),
      .load   (step),
      .item   (out_item),
      .free   (out_free),
      .rsp_ch (rsp_ch)
   );
endmodule

/* test/tb_i2c_master_bit_engine_top.sv */
// testbench for the i2c master bit engine: directed command table, then random bus traffic
`timescale 1ns / 100ps

module tb_i2c_master_bit_engine_top;
   import i2cm_pkg::*;

   localparam int unsigned CLK_HALF_NS = 6;
   localparam int unsigned TIMEOUT_NS  = 24_000_000;
   localparam int unsigned SQUEEZE_CYCLES = 300;

   // phases per command (per bit for send and read), indexed by command code
   localparam int PHASES_OF [8] = '{0, 2, 2, 4, 3, 5, 3, 4};

   localparam rsp_item_type NO_WORD = '0;
   localparam rsp_item_type IDLE_WORD = '{scl_out: 1'b1, sda_out: 1'b1, busy_res: 1'b0,
                                          done_res: 1'b0, rx_byte: 8'h00, ack_status: 1'b0};
   localparam rsp_item_type START_WORD = '{scl_out: 1'b1, sda_out: 1'b1, busy_res: 1'b1,
                                           done_res: 1'b0, rx_byte: 8'h00, ack_status: 1'b0};

   // one row of the directed command table
   typedef struct {
      bit           cfg_en;
      logic [15:0]  cfg_val;
      mode_type     cmd;
      logic [7:0]   tx;
      logic [7:0]   sda_pat;
      mode_type     pad_cmd;
      bit           has_exp;
      rsp_item_type exp;
   } plan_row_type;

   plan_row_type dir_plan [20] = '{
      '{1'b0, 16'd0,     MODE_NONE,     8'h00, 8'h00, MODE_NONE,     1'b1, IDLE_WORD},
      '{1'b0, 16'd0,     MODE_START,    8'hFF, 8'hFF, MODE_NONE,     1'b1, START_WORD},
      // read right after start: sda stays pulled low
      '{1'b1, 16'd1,     MODE_READ,     8'h00, 8'hA5, MODE_NONE,     1'b0, NO_WORD},
      '{1'b0, 16'd0,     MODE_SEND,     8'hFF, 8'h00, MODE_READ,     1'b0, NO_WORD},
      '{1'b0, 16'd0,     MODE_SEND,     8'h00, 8'hFF, MODE_SEND,     1'b0, NO_WORD},
      '{1'b0, 16'd0,     MODE_SEND,     8'h80, 8'h55, MODE_STOP,     1'b0, NO_WORD},
      '{1'b0, 16'd0,     MODE_SEND,     8'h01, 8'hAA, MODE_START,    1'b0, NO_WORD},
      '{1'b0, 16'd0,     MODE_WAIT_ACK, 8'h00, 8'h00, MODE_WAIT_ACK, 1'b0, NO_WORD},
      '{1'b0, 16'd0,     MODE_WAIT_ACK, 8'hFF, 8'h80, MODE_NACK,     1'b0, NO_WORD},
      '{1'b0, 16'd0,     MODE_ACK,      8'h00, 8'hFF, MODE_ACK,      1'b0, NO_WORD},
      '{1'b0, 16'd0,     MODE_NACK,     8'h00, 8'h00, MODE_NACK,     1'b0, NO_WORD},
      '{1'b0, 16'd0,     MODE_READ,     8'h00, 8'hFF, MODE_READ,     1'b0, NO_WORD},
      '{1'b0, 16'd0,     MODE_READ,     8'hFF, 8'h00, MODE_ACK,      1'b0, NO_WORD},
      '{1'b0, 16'd0,     MODE_STOP,     8'h00, 8'hFF, MODE_NONE,     1'b0, NO_WORD},
      // zero phase length acts as one
      '{1'b1, 16'd0,     MODE_START,    8'h00, 8'hFF, MODE_SEND,     1'b0, NO_WORD},
      '{1'b0, 16'd0,     MODE_READ,     8'h00, 8'h5A, MODE_STOP,     1'b0, NO_WORD},
      '{1'b1, 16'd2,     MODE_SEND,     8'hC3, 8'h3C, MODE_START,    1'b0, NO_WORD},
      '{1'b0, 16'd0,     MODE_STOP,     8'h00, 8'h00, MODE_READ,     1'b0, NO_WORD},
      // longest phase length, engine left idle
      '{1'b1, 16'hFFFF,  MODE_NONE,     8'h00, 8'hFF, MODE_NONE,     1'b0, NO_WORD},
      '{1'b1, PHASE_TICKS_RESET, MODE_STOP, 8'h00, 8'h00, MODE_NONE, 1'b0, NO_WORD}
   };

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   i2cm_req_if req_ch ();
   i2cm_rsp_if rsp_ch ();

   i2c_master_bit_engine_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   // engine state as predicted from the accepted words
   logic [15:0] phase_len  = PHASE_TICKS_RESET;
   mode_type    eng_cmd    = MODE_NONE;
   logic [2:0]  eng_phase  = '0;
   logic [15:0] eng_ticks  = '0;
   logic [3:0]  eng_bit    = '0;
   logic [7:0]  eng_shift  = '0;
   logic [7:0]  eng_rx     = '0;
   logic        eng_ack    = 1'b0;
   logic        eng_scl    = 1'b1;
   logic        eng_sda    = 1'b1;

   rsp_item_type rsp_awaited [$];
   int unsigned  fail_count  = 0;
   int unsigned  words_sent  = 0;
   int unsigned  tx_idle_pct = 0;
   int unsigned  rx_stall_pct = 0;
   bit           squeeze_req = 1'b0;
   int unsigned  squeeze_left = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #(CLK_HALF_NS) clock = ~clock;
   end

   // run limit
   initial begin
      #(TIMEOUT_NS);
      $display("i2c_master_bit_engine_top: mismatch");
      $finish;
   end

   // scl/sda action of one phase: {scl action, sda action}
   function automatic logic [3:0] plan_of(input mode_type c, input logic [2:0] p);
      case (c)
         MODE_START: return (p == 3'd0) ? {LVL_HIGH, LVL_HIGH} : {LVL_KEEP, LVL_LOW};
         MODE_STOP:  return (p == 3'd0) ? {LVL_HIGH, LVL_LOW} : {LVL_KEEP, LVL_HIGH};
         MODE_SEND: begin
            case (p)
               3'd0:    return {LVL_LOW, LVL_LOW};
               3'd1:    return {LVL_KEEP, LVL_DATA};
               3'd2:    return {LVL_HIGH, LVL_KEEP};
               default: return {LVL_LOW, LVL_KEEP};
            endcase
         end
         MODE_READ: return (p == 3'd1) ? {LVL_HIGH, LVL_KEEP} : {LVL_LOW, LVL_KEEP};
         MODE_ACK: begin
            case (p)
               3'd0:    return {LVL_LOW, LVL_HIGH};
               3'd1:    return {LVL_KEEP, LVL_LOW};
               3'd2:    return {LVL_HIGH, LVL_KEEP};
               3'd3:    return {LVL_LOW, LVL_KEEP};
               default: return {LVL_KEEP, LVL_HIGH};
            endcase
         end
         MODE_NACK: begin
            case (p)
               3'd0:    return {LVL_LOW, LVL_HIGH};
               3'd1:    return {LVL_HIGH, LVL_KEEP};
               default: return {LVL_LOW, LVL_KEEP};
            endcase
         end
         MODE_WAIT_ACK: begin
            case (p)
               3'd0:    return {LVL_LOW, LVL_HIGH};
               3'd1:    return {LVL_HIGH, LVL_KEEP};
               3'd2:    return {LVL_KEEP, LVL_KEEP};
               default: return {LVL_LOW, LVL_KEEP};
            endcase
         end
         default: return {LVL_KEEP, LVL_KEEP};
      endcase
   endfunction

   // put the current phase's levels on the predicted lines
   function automatic void drive_lines();
      logic [3:0] act;
      act = plan_of(eng_cmd, eng_phase);
      if (act[3:2] != LVL_KEEP) eng_scl = act[2];
      if (act[1:0] == LVL_DATA) eng_sda = eng_shift[7];
      else if (act[1:0] != LVL_KEEP) eng_sda = act[0];
   endfunction

   // advance the engine by one tick and return the line/status word it shows
   function automatic rsp_item_type predict_tick(input mode_type m, input logic [7:0] tx,
                                                 input logic s);
      logic [15:0]  limit;
      logic         fin;
      rsp_item_type r;
      limit = (phase_len == 16'd0) ? 16'd1 : phase_len;
      fin = 1'b0;
      if (eng_cmd != MODE_NONE) begin
         if (eng_ticks != 16'hFFFF) eng_ticks++;
         if (eng_ticks >= limit) begin
            eng_ticks = '0;
            // sample sda as the scl-high phase ends
            if (eng_phase == 3'd1 && eng_cmd == MODE_READ) eng_shift = {eng_shift[6:0], s};
            if (eng_phase == 3'd1 && eng_cmd == MODE_WAIT_ACK) eng_ack = s;
            if (int'(eng_phase) + 1 >= PHASES_OF[eng_cmd]) begin
               if (eng_cmd == MODE_SEND) eng_shift = eng_shift << 1;
               if ((eng_cmd == MODE_SEND || eng_cmd == MODE_READ) && eng_bit < LAST_BIT) begin
                  eng_bit++;
                  eng_phase = '0;
                  drive_lines();
               end else begin
                  if (eng_cmd == MODE_READ) eng_rx = eng_shift;
                  eng_cmd = MODE_NONE;
                  eng_phase = '0;
                  fin = 1'b1;
               end
            end else begin
               eng_phase++;
               drive_lines();
            end
         end
      end else if (m != MODE_NONE) begin
         eng_cmd = m;
         eng_phase = '0;
         eng_ticks = '0;
         eng_bit = '0;
         eng_shift = (m == MODE_SEND) ? tx : 8'h00;
         drive_lines();
      end
      r.scl_out = eng_scl;
      r.sda_out = eng_sda;
      r.busy_res = (eng_cmd != MODE_NONE);
      r.done_res = fin;
      r.rx_byte = eng_rx;
      r.ack_status = eng_ack;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      fail_count++;
      $display("%0t ns: %s is %0h, expected %0h", $time, what, got, want);
   endtask

   // offer one tick word, wait for it to be taken, record its expected response
   task automatic send_word(input mode_type m, input logic [7:0] tx, input logic s,
                            input bit has_exp, input rsp_item_type exp);
      rsp_item_type r;
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.mode    <= m;
      req_ch.tx_byte <= tx;
      req_ch.sda_in  <= s;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      r = predict_tick(m, tx, s);
      rsp_awaited.push_back(has_exp ? exp : r);
      words_sent++;
      @(negedge clock);
   endtask

   // start one command and keep ticking until the engine is idle again
   task automatic issue_command(input mode_type m, input logic [7:0] tx, input logic s,
                                input bit has_exp, input rsp_item_type exp,
                                input mode_type pad_cmd, input logic [7:0] pat,
                                input bit rand_pad);
      send_word(m, tx, s, has_exp, exp);
      while (eng_cmd != MODE_NONE) begin
         if (rand_pad)
            send_word(mode_type'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                      1'b0, NO_WORD);
         else
            send_word(pad_cmd, tx, pat[3'(LAST_BIT - eng_bit)], 1'b0, NO_WORD);
      end
   endtask

   task automatic issue_random(input mode_type m);
      issue_command(m, 8'($urandom), 1'($urandom), 1'b0, NO_WORD, MODE_NONE, 8'h00, 1'b1);
   endtask

   // phase length changes only with the engine idle and every word back
   task automatic write_phase_ticks(input logic [15:0] v);
      req_ch.valid <= 1'b0;
      while (rsp_awaited.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      phase_len = v;
   endtask

   // random traffic: some whole bus transfers, mostly loose commands
   task automatic run_random(input logic [15:0] len, input int unsigned s_idle,
                             input int unsigned r_stall, input int unsigned n_words,
                             input bit squeeze);
      int unsigned target;
      int unsigned k;
      target = words_sent + n_words;
      write_phase_ticks(len);
      tx_idle_pct = s_idle;
      rx_stall_pct = r_stall;
      if (squeeze) squeeze_req = 1'b1;
      while (words_sent < target) begin
         if ($urandom_range(0, 99) < 30) begin
            issue_random(MODE_START);
            issue_random(MODE_SEND);
            issue_random(MODE_WAIT_ACK);
            k = $urandom_range(0, 1);
            repeat (k) begin
               if ($urandom_range(0, 1) == 0) begin
                  issue_random(MODE_SEND);
                  issue_random(MODE_WAIT_ACK);
               end else begin
                  issue_random(MODE_READ);
                  issue_random(($urandom_range(0, 1) == 0) ? MODE_ACK : MODE_NACK);
               end
            end
            issue_random(MODE_STOP);
         end else begin
            issue_random(mode_type'($urandom_range(0, 7)));
         end
      end
   endtask

   // response side: random stalls plus an occasional long hold-off
   always @(negedge clock) begin
      if (squeeze_req) begin
         squeeze_left = SQUEEZE_CYCLES;
         squeeze_req = 1'b0;
      end
      if (squeeze_left > 0) begin
         squeeze_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
   end

   // compare each taken response word with the oldest expected one
   always @(posedge clock) begin
      rsp_item_type seen;
      rsp_item_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         seen = {rsp_ch.scl_out, rsp_ch.sda_out, rsp_ch.busy_res, rsp_ch.done_res,
                 rsp_ch.rx_byte, rsp_ch.ack_status};
         if (rsp_awaited.size() == 0) begin
            report_mismatch("word with nothing awaited, rx_byte", seen.rx_byte, 8'h00);
         end else begin
            want = rsp_awaited.pop_front();
            if (seen.scl_out !== want.scl_out)
               report_mismatch("scl_out", 8'(seen.scl_out), 8'(want.scl_out));
            if (seen.sda_out !== want.sda_out)
               report_mismatch("sda_out", 8'(seen.sda_out), 8'(want.sda_out));
            if (seen.busy_res !== want.busy_res)
               report_mismatch("busy_res", 8'(seen.busy_res), 8'(want.busy_res));
            if (seen.done_res !== want.done_res)
               report_mismatch("done_res", 8'(seen.done_res), 8'(want.done_res));
            if (seen.rx_byte !== want.rx_byte)
               report_mismatch("rx_byte", seen.rx_byte, want.rx_byte);
            if (seen.ack_status !== want.ack_status)
               report_mismatch("ack_status", 8'(seen.ack_status), 8'(want.ack_status));
         end
      end
   end

   // main sequence
   initial begin
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      req_ch.valid   = 1'b0;
      req_ch.mode    = MODE_NONE;
      req_ch.tx_byte = '0;
      req_ch.sda_in  = 1'b0;
      rsp_ch.ready   = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed commands, no idling
      foreach (dir_plan[i]) begin
         if (dir_plan[i].cfg_en) write_phase_ticks(dir_plan[i].cfg_val);
         issue_command(dir_plan[i].cmd, dir_plan[i].tx, dir_plan[i].sda_pat[7],
                       dir_plan[i].has_exp, dir_plan[i].exp, dir_plan[i].pad_cmd,
                       dir_plan[i].sda_pat, 1'b0);
      end

      // random traffic over short phase lengths, idle and stall patterns
      run_random(16'd1, 0, 0, 20, 1'b0);
      run_random(16'd2, 67, 0, 20, 1'b0);
      run_random(16'd1, 0, 67, 20, 1'b1);
      run_random(16'($urandom_range(1, 2)), 29, 29, 20, 1'b0);

      // drain
      req_ch.valid <= 1'b0;
      rx_stall_pct = 0;
      while (rsp_awaited.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      if (fail_count == 0)
         $display("i2c_master_bit_engine_top: match");
      else
         $display("i2c_master_bit_engine_top: mismatch");
      $finish;
   end

endmodule
